// ===== rtl/ttcs_pkg.sv =====
// Shared constants and types for the text terminal cursor/scroll block.
// Used by the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package ttcs_pkg;

  // Grid geometry. The cell address is {physical row, column}, so both
  // dimensions are powers of two.
  localparam int COLUMNS    = 64;
  localparam int ROWS       = 32;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int CODE_W     = 8;
  localparam int CELL_W     = CODE_W + 1;
  localparam int GRID_DEPTH = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
  localparam logic [CODE_W-1:0] CODE_LF = 8'd10;

  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // One grid cell: font flag above the character code.
  typedef struct packed {
    logic              font;
    logic [CODE_W-1:0] code;
  } cell_t;

endpackage

// ===== rtl/text_terminal_cursor_scroll.sv =====
// A print shows its result the cycle after acceptance; a read goes through the registered
// RAM read, then the output registers. Prints: one per cycle while in_stall is low; reads
// not back to back (single read port). A scroll clears the new bottom row, one cell per
// cycle. Reset (rst_n low, synchronous): cursor and scroll base go to 0, then a clearing
// pass writes all 2048 cells to zero, one per cycle, with in_stall high.
`timescale 1ns / 1ps

module text_terminal_cursor_scroll
  import ttcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [CODE_W-1:0] in_code,
  input  logic              in_font_custom,
  input  logic [COL_W-1:0]  in_read_column,
  input  logic [ROW_W-1:0]  in_read_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_wrote_cell,
  output logic              out_scrolled,
  output logic [COL_W-1:0]  out_cell_column,
  output logic [ROW_W-1:0]  out_cell_row,
  output logic [CODE_W-1:0] out_cell_code,
  output logic              out_cell_font,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_row
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_SCROLL = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  // Physical row of logical row 0; scrolling bumps it instead of copying.
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              rd_in_r;
  logic [COL_W-1:0]  rd_col_r;
  logic [ROW_W-1:0]  rd_row_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_wrote_r, out_scrolled_r, out_font_r;
  logic [COL_W-1:0]  out_ccol_r, out_curcol_r;
  logic [ROW_W-1:0]  out_crow_r, out_currow_r;
  logic [CODE_W-1:0] out_code_r;

  logic              in_accept;
  logic              is_print, is_cr, is_lf, is_char;
  logic [COL_W:0]    col_inc;
  logic              col_wrap, at_last_row, do_scroll;
  logic              read_inside;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  cell_t             mem_wdata, mem_rdata;

  assign in_stall  = (st_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign is_print    = in_accept && (in_op == OP_PRINT);
  assign is_cr       = is_print && (in_code == CODE_CR);
  assign is_lf       = is_print && (in_code == CODE_LF);
  assign is_char     = is_print && !is_cr && !is_lf;
  assign col_inc     = {1'b0, cur_col_r} + (COL_W+1)'(1);
  assign col_wrap    = col_inc >= (COL_W+1)'(COLUMNS);
  assign at_last_row = cur_row_r == LAST_ROW;
  assign do_scroll   = at_last_row && (is_lf || (is_char && col_wrap));
  assign read_inside = (int'(in_read_column) < COLUMNS) && (int'(in_read_row) < ROWS);

  ttcs_ram #(.WIDTH(CELL_W), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign mem_re    = in_accept && (in_op == OP_READ) && read_inside;
  assign mem_raddr = {in_read_row + base_r, in_read_column};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    case (st_r)
      ST_CLEAR, ST_SCROLL: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we         = is_char;
        mem_waddr      = {cur_row_r + base_r, cur_col_r};
        mem_wdata.font = in_font_custom;
        mem_wdata.code = in_code;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt       = st_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    base_nxt     = base_r;
    clr_addr_nxt = clr_addr_r;
    case (st_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(GRID_DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && (in_op == OP_READ)) begin
          st_nxt = ST_READ;
        end
        if (is_cr) begin
          cur_col_nxt = '0;
        end
        if (is_char) begin
          cur_col_nxt = col_wrap ? '0 : col_inc[COL_W-1:0];
        end
        if ((is_lf || (is_char && col_wrap)) && !at_last_row) begin
          cur_row_nxt = cur_row_r + ROW_W'(1);
        end
        if (do_scroll) begin
          // old base row becomes the new bottom row; clear it
          base_nxt     = base_r + ROW_W'(1);
          clr_addr_nxt = {base_r, COL_W'(0)};
          st_nxt       = ST_SCROLL;
        end
      end
      ST_READ: begin
        st_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r[COL_W-1:0] == LAST_COL) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (is_print || (st_r == ST_READ)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      base_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      base_r      <= base_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept && (in_op == OP_READ)) begin
      rd_in_r  <= read_inside;
      rd_col_r <= in_read_column;
      rd_row_r <= in_read_row;
    end
    if (is_print) begin
      out_wrote_r    <= is_char;
      out_scrolled_r <= do_scroll;
      out_ccol_r     <= is_char ? cur_col_r : '0;
      out_crow_r     <= is_char ? cur_row_r : '0;
      out_code_r     <= is_char ? in_code : '0;
      out_font_r     <= is_char ? in_font_custom : 1'b0;
      out_curcol_r   <= cur_col_nxt;
      out_currow_r   <= cur_row_nxt;
    end else if (st_r == ST_READ) begin
      out_wrote_r    <= 1'b0;
      out_scrolled_r <= 1'b0;
      out_ccol_r     <= rd_col_r;
      out_crow_r     <= rd_row_r;
      out_code_r     <= rd_in_r ? mem_rdata.code : '0;
      out_font_r     <= rd_in_r ? mem_rdata.font : 1'b0;
      out_curcol_r   <= cur_col_r;
      out_currow_r   <= cur_row_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wrote_cell    = out_wrote_r;
  assign out_scrolled      = out_scrolled_r;
  assign out_cell_column   = out_ccol_r;
  assign out_cell_row      = out_crow_r;
  assign out_cell_code     = out_code_r;
  assign out_cell_font     = out_font_r;
  assign out_cursor_column = out_curcol_r;
  assign out_cursor_row    = out_currow_r;

endmodule

// ===== rtl/ttcs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ttcs_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ttcs_checker.sv =====
// Port-level checker for text_terminal_cursor_scroll, bound to the top level.
// Depends on ttcs_pkg.
`timescale 1ns / 1ps

module ttcs_checker
  import ttcs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_op,
  input logic [CODE_W-1:0] in_code,
  input logic              in_font_custom,
  input logic [COL_W-1:0]  in_read_column,
  input logic [ROW_W-1:0]  in_read_row,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_wrote_cell,
  input logic              out_scrolled,
  input logic [COL_W-1:0]  out_cell_column,
  input logic [ROW_W-1:0]  out_cell_row,
  input logic [CODE_W-1:0] out_cell_code,
  input logic              out_cell_font,
  input logic [COL_W-1:0]  out_cursor_column,
  input logic [ROW_W-1:0]  out_cursor_row
);

  // Grid clear after reset holds off input and leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("input accepted or result pending right after reset");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_code)
      && $stable(out_cursor_column) && $stable(out_cursor_row))
    else $error("stalled result changed");

  // A scroll always leaves the cursor on the bottom row.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_row == LAST_ROW)
    else $error("scroll with cursor off the bottom row");

  // A stored character without column wrap advances the cursor by one.
  a_char_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrote_cell && out_cell_column != LAST_COL |->
      out_cursor_column == out_cell_column + COL_W'(1) && out_cursor_row == out_cell_row
      && !out_scrolled)
    else $error("cursor did not advance after a stored character");

  // A wrapped character lands the cursor at column zero.
  a_char_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrote_cell && out_cell_column == LAST_COL |->
      out_cursor_column == '0)
    else $error("cursor column not zero after wrap");

endmodule

bind text_terminal_cursor_scroll ttcs_checker u_ttcs_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the text terminal cursor/scroll block.
// Depends on rtl/ttcs_pkg.sv and rtl/text_terminal_cursor_scroll.sv.
`timescale 1ns / 1ps

module testbench;
  import ttcs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int TEXT_ITEMS  = 930;
  localparam int NOISE_ITEMS = 220;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic              wrote_cell;
    logic              scrolled;
    logic [COL_W-1:0]  cell_column;
    logic [ROW_W-1:0]  cell_row;
    logic [CODE_W-1:0] cell_code;
    logic              cell_font;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } term_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_PRINT;
  logic [CODE_W-1:0] in_code = '0;
  logic              in_font_custom = 1'b0;
  logic [COL_W-1:0]  in_read_column = '0;
  logic [ROW_W-1:0]  in_read_row = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_wrote_cell;
  logic              out_scrolled;
  logic [COL_W-1:0]  out_cell_column;
  logic [ROW_W-1:0]  out_cell_row;
  logic [CODE_W-1:0] out_cell_code;
  logic              out_cell_font;
  logic [COL_W-1:0]  out_cursor_column;
  logic [ROW_W-1:0]  out_cursor_row;

  text_terminal_cursor_scroll dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_code          (in_code),
    .in_font_custom   (in_font_custom),
    .in_read_column   (in_read_column),
    .in_read_row      (in_read_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wrote_cell   (out_wrote_cell),
    .out_scrolled     (out_scrolled),
    .out_cell_column  (out_cell_column),
    .out_cell_row     (out_cell_row),
    .out_cell_code    (out_cell_code),
    .out_cell_font    (out_cell_font),
    .out_cursor_column(out_cursor_column),
    .out_cursor_row   (out_cursor_row)
  );

  // Shadow copy of the screen and cursor
  cell_t            screen_model [0:ROWS-1][0:COLUMNS-1];
  logic [COL_W-1:0] model_col;
  logic [ROW_W-1:0] model_row;
  term_result_t     expected_results [$];

  int fail_count = 0;
  int items_sent = 0;
  int prints_sent = 0;
  int reads_sent = 0;
  int scroll_count = 0;
  int wrap_count = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++)
        screen_model[r][c] = '0;
    model_col = '0;
    model_row = '0;
  end

  function automatic logic model_line_feed();
    if (model_row == LAST_ROW) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen_model[r][c] = screen_model[r + 1][c];
      for (int c = 0; c < COLUMNS; c++)
        screen_model[ROWS - 1][c] = '0;
      return 1'b1;
    end
    model_row = model_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic term_result_t predict_terminal(input logic op,
                                                    input logic [CODE_W-1:0] code,
                                                    input logic font,
                                                    input logic [COL_W-1:0] rcol,
                                                    input logic [ROW_W-1:0] rrow);
    term_result_t res;
    res = '0;
    if (op == OP_READ) begin
      res.cell_column = rcol;
      res.cell_row    = rrow;
      if (int'(rcol) < COLUMNS && int'(rrow) < ROWS) begin
        res.cell_code = screen_model[rrow][rcol].code;
        res.cell_font = screen_model[rrow][rcol].font;
      end
    end else if (code == CODE_CR) begin
      model_col = '0;
    end else if (code == CODE_LF) begin
      res.scrolled = model_line_feed();
    end else begin
      screen_model[model_row][model_col] = {font, code};
      res.wrote_cell  = 1'b1;
      res.cell_column = model_col;
      res.cell_row    = model_row;
      res.cell_code   = code;
      res.cell_font   = font;
      if (model_col == LAST_COL) begin
        res.scrolled = model_line_feed();
        model_col    = '0;
      end else begin
        model_col = model_col + 1'b1;
      end
    end
    res.cursor_column = model_col;
    res.cursor_row    = model_row;
    return res;
  endfunction

  // Sender pacing: bursts of random length, random gaps in between
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_item(input logic op, input logic [CODE_W-1:0] code, input logic font,
                           input logic [COL_W-1:0] rcol, input logic [ROW_W-1:0] rrow);
    term_result_t res;
    in_valid       <= 1'b1;
    in_op          <= op;
    in_code        <= code;
    in_font_custom <= font;
    in_read_column <= rcol;
    in_read_row    <= rrow;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_terminal(op, code, font, rcol, rrow);
    expected_results.push_back(res);
    items_sent++;
    if (op == OP_READ) begin
      reads_sent++;
    end else begin
      prints_sent++;
      if (res.scrolled) scroll_count++;
      if (res.wrote_cell && res.cell_column == LAST_COL) wrap_count++;
    end
    pace_sender();
  endtask

  // Unused fields of each transaction carry random values
  task automatic send_print(input logic [CODE_W-1:0] code, input logic font);
    send_item(OP_PRINT, code, font, COL_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic send_read(input logic [COL_W-1:0] rcol, input logic [ROW_W-1:0] rrow);
    send_item(OP_READ, CODE_W'($urandom), 1'($urandom), rcol, rrow);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CODE_W-1:0] random_printable();
    logic [CODE_W-1:0] code;
    code = CODE_W'($urandom);
    while (code == CODE_CR || code == CODE_LF) code = CODE_W'($urandom);
    return code;
  endfunction

  // After the clearing pass the four corner cells read back as zero
  task automatic test_reset_contents();
    send_read('0, '0);
    send_read(LAST_COL, LAST_ROW);
    send_read(LAST_COL, '0);
    send_read('0, LAST_ROW);
  endtask

  task automatic test_control_codes();
    send_print(8'h00, 1'b0);
    send_print(8'hFF, 1'b1);
    send_print(CODE_CR, 1'b1);
    send_print(CODE_LF, 1'b0);
    send_print(8'h41, 1'b1);
    send_print(CODE_LF - 1'b1, 1'b0);
    send_print(CODE_CR + 1'b1, 1'b1);
    send_print(CODE_LF + 1'b1, 1'b0);
    send_read('0, '0);
    send_read(COL_W'(1), '0);
    send_read('0, ROW_W'(1));
    send_read(COL_W'(3), ROW_W'(1));
    send_print(CODE_LF, 1'b1);
    send_print(CODE_CR, 1'b0);
    // Read carrying a control code in its code field must not move the cursor
    send_item(OP_READ, CODE_CR, 1'b1, COL_W'(2), ROW_W'(1));
    send_item(OP_READ, CODE_LF, 1'b0, LAST_COL, LAST_ROW);
    send_item(OP_PRINT, 8'h7E, 1'b1, LAST_COL, LAST_ROW);
    send_read('0, ROW_W'(2));
  endtask

  // Lines of random text with line endings and interleaved reads, long lines that wrap, and
  // runs of line feeds that push the cursor to the bottom and scroll.
  task automatic test_text_lines();
    int line_len;
    int line_no;
    int ending;
    int back;
    line_no = 0;
    while (items_sent < TEXT_ITEMS) begin
      line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 24);
      for (int i = 0; i < line_len; i++) begin
        send_print(random_printable(), 1'($urandom));
        if ($urandom_range(0, 6) == 0) begin
          back = $urandom_range(0, 3);
          if ($urandom_range(0, 3) == 0)
            send_read(COL_W'($urandom), ROW_W'($urandom));
          else
            send_read(COL_W'($urandom),
                      (int'(model_row) >= back) ? ROW_W'(int'(model_row) - back) : '0);
        end
      end
      ending = $urandom_range(0, 9);
      case (ending)
        0, 1, 2, 3, 4: begin
          send_print(CODE_CR, 1'($urandom));
          send_print(CODE_LF, 1'($urandom));
        end
        5, 6: send_print(CODE_LF, 1'($urandom));
        7: send_print(CODE_CR, 1'($urandom));
        8: begin
          send_print(CODE_LF, 1'($urandom));
          send_print(CODE_CR, 1'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 40)) send_print(CODE_LF, 1'($urandom));
        end
      endcase
      line_no++;
      if (line_no % 8 == 0) wait_results_drained();
    end
  endtask

  // Unstructured transactions, biased toward the control codes
  task automatic test_noise();
    logic [CODE_W-1:0] code;
    int pick;
    for (int i = 0; i < NOISE_ITEMS; i++) begin
      pick = $urandom_range(0, 7);
      code = (pick == 0) ? CODE_CR : (pick == 1) ? CODE_LF : CODE_W'($urandom);
      send_item(1'($urandom), code, 1'($urandom), COL_W'($urandom), ROW_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_reset_contents();
    test_control_codes();
    wait_results_drained();
    test_text_lines();
    test_noise();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d transactions (%0d prints, %0d reads) with %0d scrolls and %0d line wraps,",
             items_sent, prints_sent, reads_sent, scroll_count, wrap_count);
    $display("checked %0d results against the shadow screen; %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Result receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        run_stall = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_stall <= ~run_stall;
            run_left  <= $urandom_range(1, 24);
          end else begin
            run_left <= run_left - 1;
          end
          out_stall <= run_stall;
        end
      endcase
    end
  end

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                 results_checked, name, want_v, got_v);
    end
  endtask

  term_result_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Unexpected result transaction at cycle %0d", cycle_count);
      end else begin
        want_res = expected_results.pop_front();
        check_field("wrote_cell", want_res.wrote_cell, out_wrote_cell);
        check_field("scrolled", want_res.scrolled, out_scrolled);
        check_field("cell_column", want_res.cell_column, out_cell_column);
        check_field("cell_row", want_res.cell_row, out_cell_row);
        check_field("cell_code", want_res.cell_code, out_cell_code);
        check_field("cell_font", want_res.cell_font, out_cell_font);
        check_field("cursor_column", want_res.cursor_column, out_cursor_column);
        check_field("cursor_row", want_res.cursor_row, out_cursor_row);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule
